FILE: rtl/ldps_pkg.sv
// ----------------------------------------------------------------------------
// ldps_pkg
// Shared types, codes, constants and arithmetic helpers of the pixel smear.
// ----------------------------------------------------------------------------
package ldps_pkg;

  // Operation codes carried on the input tuser
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE         = 3'd0;
  localparam logic [2:0] REG_THRESHOLD    = 3'd1;
  localparam logic [2:0] REG_SMEAR_LENGTH = 3'd2;
  localparam logic [2:0] REG_MIX          = 3'd3;
  localparam logic [2:0] REG_CHROMA       = 3'd4;
  localparam logic [2:0] REG_DRIVE        = 3'd5;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd6;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Register reset values
  localparam logic [1:0]  RST_MODE      = 2'd0;
  localparam logic [7:0]  RST_THRESHOLD = 8'd1;
  localparam logic [11:0] RST_LENGTH    = 12'd1000;
  localparam logic [9:0]  RST_MIX       = 10'd1000;
  localparam logic [9:0]  RST_CHROMA    = 10'd1000;
  localparam logic [9:0]  RST_DRIVE     = 10'd0;
  localparam logic [10:0] RST_FW        = 11'd1024;
  localparam logic [10:0] RST_FH        = 11'd1024;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam logic [11:0] LEN_MAX   = 12'd3000;
  localparam logic [9:0]  PERMILLE  = 10'd1000;
  localparam logic [20:0] ROUND_HALF = 21'd500;
  localparam logic [20:0] THR_DRIVE = 21'd96;
  localparam logic [20:0] LEN_DRIVE = 21'd2000;

  // ceil(2^32 / 1000): exact floor(v / 1000) for every v below 2^21
  localparam logic [43:0] DIV1000_RECIP = 44'd4294968;

  // Output queue depth and cycles the derived settings need after a write
  localparam int         OFIFO_DEPTH = 8;
  localparam logic [2:0] CFG_SETTLE  = 3'd4;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  // Effective settings handed to the datapath
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  ethr;
    logic [11:0] elen;
    logic [8:0]  mq;
    logic [8:0]  cq;
  } ldps_prm_t;

  // Datapath status towards the input handshake
  typedef struct packed {
    logic src_rd;  // source read owns the frame-store port this cycle
    logic busy;    // a compute has not yet issued its source read
    logic issue;   // this beat starts a compute that gives a result
  } ldps_stat_t;

  typedef struct packed {
    logic       smeared;
    logic [7:0] cr;
    logic [7:0] cb;
    logic [7:0] luma;
  } ldps_res_t;

  function automatic logic [10:0] div1000(input logic [20:0] v);
    logic [43:0] p;
    p = 44'(v) * DIV1000_RECIP;
    return p[42:32];
  endfunction

  // (a*(256-q) + b*q + 128) >> 8, q in 0..256
  function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [8:0] q);
    logic [16:0] s;
    s = 17'(a) * 17'(9'd256 - q) + 17'(b) * 17'(q) + 17'd128;
    return s[15:8];
  endfunction

endpackage

FILE: rtl/ldps_ram.sv
// ----------------------------------------------------------------------------
// ldps_ram
// Single-port synchronous RAM, registered read, write does not update rdata.
// ----------------------------------------------------------------------------
module ldps_ram #(
  parameter int DW    = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ldps_cfg.sv
// ----------------------------------------------------------------------------
// ldps_cfg
// Register file and staged derivation of the effective smear settings.
// ----------------------------------------------------------------------------
module ldps_cfg #(
  parameter int MAX_WIDTH  = ldps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ldps_pkg::MAX_HEIGHT_DEF,
  parameter int XW         = 11,
  parameter int YW         = 11
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              we_i,
  input  logic [ldps_pkg::CFG_IDX_W-1:0]    idx_i,
  input  logic [ldps_pkg::CFG_DATA_W-1:0]   data_i,
  output ldps_pkg::ldps_prm_t               prm_o,
  output logic [XW-1:0]                     fw_o,
  output logic [YW-1:0]                     fh_o,
  output logic                              busy_o
);

  logic [1:0]  mode_q;
  logic [7:0]  thr_q;
  logic [11:0] len_q;
  logic [9:0]  mix_q, chr_q, drv_q;
  logic [10:0] fw_q, fh_q;
  logic [2:0]  settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ldps_pkg::RST_MODE;
      thr_q    <= ldps_pkg::RST_THRESHOLD;
      len_q    <= ldps_pkg::RST_LENGTH;
      mix_q    <= ldps_pkg::RST_MIX;
      chr_q    <= ldps_pkg::RST_CHROMA;
      drv_q    <= ldps_pkg::RST_DRIVE;
      fw_q     <= ldps_pkg::RST_FW;
      fh_q     <= ldps_pkg::RST_FH;
      settle_q <= ldps_pkg::CFG_SETTLE;
    end else begin
      if (we_i) begin
        settle_q <= ldps_pkg::CFG_SETTLE;
        case (idx_i)
          ldps_pkg::REG_MODE:         mode_q <= data_i[1:0];
          ldps_pkg::REG_THRESHOLD:    thr_q  <= data_i[7:0];
          ldps_pkg::REG_SMEAR_LENGTH: len_q  <= data_i[11:0];
          ldps_pkg::REG_MIX:          mix_q  <= data_i[9:0];
          ldps_pkg::REG_CHROMA:       chr_q  <= data_i[9:0];
          ldps_pkg::REG_DRIVE:        drv_q  <= data_i[9:0];
          ldps_pkg::REG_FRAME_WIDTH:  fw_q   <= data_i[10:0];
          ldps_pkg::REG_FRAME_HEIGHT: fh_q   <= data_i[10:0];
          default: ;
        endcase
      end else if (settle_q != 3'd0) begin
        settle_q <= settle_q - 3'd1;
      end
    end
  end

  assign busy_o = (settle_q != 3'd0);

  // Stage a: clamps and drive products
  logic [11:0] len_c;
  logic [9:0]  mix_c, chr_c, drv_c;
  logic [XW-1:0] fw_d;
  logic [YW-1:0] fh_d;

  always_comb begin
    len_c = (len_q > ldps_pkg::LEN_MAX) ? ldps_pkg::LEN_MAX : len_q;
    mix_c = (mix_q > ldps_pkg::PERMILLE) ? ldps_pkg::PERMILLE : mix_q;
    chr_c = (chr_q > ldps_pkg::PERMILLE) ? ldps_pkg::PERMILLE : chr_q;
    drv_c = (drv_q > ldps_pkg::PERMILLE) ? ldps_pkg::PERMILLE : drv_q;
    if (fw_q == 11'd0) begin
      fw_d = XW'(1);
    end else if (XW'(fw_q) > XW'(MAX_WIDTH)) begin
      fw_d = XW'(MAX_WIDTH);
    end else begin
      fw_d = XW'(fw_q);
    end
    if (fh_q == 11'd0) begin
      fh_d = YW'(1);
    end else if (YW'(fh_q) > YW'(MAX_HEIGHT)) begin
      fh_d = YW'(MAX_HEIGHT);
    end else begin
      fh_d = YW'(fh_q);
    end
  end

  logic [XW-1:0] fw_q2;
  logic [YW-1:0] fh_q2;
  logic [11:0]   len_a_q;
  logic [9:0]    mix_a_q, chr_a_q;
  logic [20:0]   t_thr_q, t_len_q, t_mix_q, t_chr_q;

  always_ff @(posedge clk_i) begin
    fw_q2   <= fw_d;
    fh_q2   <= fh_d;
    len_a_q <= len_c;
    mix_a_q <= mix_c;
    chr_a_q <= chr_c;
    t_thr_q <= 21'(drv_c) * ldps_pkg::THR_DRIVE + ldps_pkg::ROUND_HALF;
    t_len_q <= 21'(drv_c) * ldps_pkg::LEN_DRIVE + ldps_pkg::ROUND_HALF;
    t_mix_q <= 21'(ldps_pkg::PERMILLE - mix_c) * 21'(drv_c) + ldps_pkg::ROUND_HALF;
    t_chr_q <= 21'(ldps_pkg::PERMILLE - chr_c) * 21'(drv_c) + ldps_pkg::ROUND_HALF;
  end

  // Stage b: divide the drive terms by 1000
  logic [10:0] q_thr, q_len, q_mix, q_chr;
  logic [10:0] dthr_q, dlen_q;
  logic [11:0] len_b_q;
  logic [9:0]  emix_q, echr_q;

  always_comb begin
    q_thr = ldps_pkg::div1000(t_thr_q);
    q_len = ldps_pkg::div1000(t_len_q);
    q_mix = ldps_pkg::div1000(t_mix_q);
    q_chr = ldps_pkg::div1000(t_chr_q);
  end

  always_ff @(posedge clk_i) begin
    dthr_q  <= q_thr;
    dlen_q  <= q_len;
    len_b_q <= len_a_q;
    emix_q  <= mix_a_q + q_mix[9:0];
    echr_q  <= chr_a_q + q_chr[9:0];
  end

  // Stage c: effective threshold and length, permille to 1/256 steps
  logic [12:0] elen_sum;
  logic [10:0] q_mq, q_cq;
  logic [7:0]  ethr_q;
  logic [11:0] elen_q;
  logic [8:0]  mq_q, cqp_q;

  always_comb begin
    elen_sum = 13'(len_b_q) + 13'(dlen_q);
    q_mq     = ldps_pkg::div1000(21'({emix_q, 8'd0}) + ldps_pkg::ROUND_HALF);
    q_cq     = ldps_pkg::div1000(21'({echr_q, 8'd0}) + ldps_pkg::ROUND_HALF);
  end

  always_ff @(posedge clk_i) begin
    ethr_q <= (11'(thr_q) > dthr_q) ? thr_q - dthr_q[7:0] : 8'd0;
    elen_q <= (elen_sum > 13'(ldps_pkg::LEN_MAX)) ? ldps_pkg::LEN_MAX : elen_sum[11:0];
    mq_q   <= q_mq[8:0];
    cqp_q  <= q_cq[8:0];
  end

  // Stage d: chroma share scaled by the luma mix
  logic [16:0] cq_prod;
  logic [8:0]  cq_q;

  assign cq_prod = 17'(mq_q) * 17'(cqp_q) + 17'd128;

  always_ff @(posedge clk_i) begin
    cq_q <= cq_prod[16:8];
  end

  assign prm_o.mode = mode_q;
  assign prm_o.ethr = ethr_q;
  assign prm_o.elen = elen_q;
  assign prm_o.mq   = mq_q;
  assign prm_o.cq   = cq_q;
  assign fw_o       = fw_q2;
  assign fh_o       = fh_q2;

endmodule

FILE: rtl/ldps_fifo.sv
// ----------------------------------------------------------------------------
// ldps_fifo
// Result queue in flip-flops; the writer reserves space ahead of each push.
// ----------------------------------------------------------------------------
module ldps_fifo #(
  parameter int DW    = 25,
  parameter int DEPTH = ldps_pkg::OFIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_pop;

  assign do_pop = pop_i && (cnt_q != CW'(0));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(do_pop);
    end
  end

  assign valid_o = (cnt_q != CW'(0));
  assign data_o  = mem_q[rd_q];

endmodule

FILE: rtl/ldps_dpath.sv
// ----------------------------------------------------------------------------
// ldps_dpath
// Frame store and compute pipeline: current read, distance, source read,
// average and blend.
// ----------------------------------------------------------------------------
module ldps_dpath #(
  parameter int MAX_WIDTH  = ldps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ldps_pkg::MAX_HEIGHT_DEF,
  parameter int XW         = 11,
  parameter int YW         = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  logic                 op_i,
  input  logic [9:0]           col_i,
  input  logic [9:0]           line_i,
  input  logic [23:0]          pix_i,
  input  ldps_pkg::ldps_prm_t  prm_i,
  input  logic [XW-1:0]        fw_i,
  input  logic [YW-1:0]        fh_i,
  output ldps_pkg::ldps_stat_t stat_o,
  output logic                 push_o,
  output ldps_pkg::ldps_res_t  res_o
);

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic          in_frame, in_store, cmp_go, ld_go;
  logic [AW-1:0] cur_addr, src_addr, ram_addr;
  logic          ram_en, ram_we;
  logic [23:0]   ram_rdata;

  // Pipeline registers
  logic        s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [9:0]  s1_x_q, s1_y_q, s2_x_q, s2_y_q, s3_x_q, s3_y_q;
  logic [23:0] s2_cur_q, s3_cur_q, s4_cur_q;
  logic        s2_pass_q, s3_pass_q, s4_pass_q;
  logic [19:0] s2_prod_q;
  logic [9:0]  s3_dist_q;

  assign in_frame = (XW'(col_i) < fw_i) && (YW'(line_i) < fh_i);
  assign in_store = (XW'(col_i) < XW'(MAX_WIDTH)) && (YW'(line_i) < YW'(MAX_HEIGHT));
  assign cmp_go   = acc_i && (op_i == ldps_pkg::OP_COMPUTE) && in_frame;
  assign ld_go    = acc_i && (op_i == ldps_pkg::OP_LOAD) && in_store;
  assign cur_addr = AW'(line_i) * AW'(MAX_WIDTH) + AW'(col_i);

  // Source location, clamped to the last column or row in use
  logic [XW-1:0] sx_sum, src_x;
  logic [YW-1:0] sy_sum, src_y;

  always_comb begin
    sx_sum = XW'(s3_x_q) + XW'(s3_dist_q);
    sy_sum = YW'(s3_y_q) + YW'(s3_dist_q);
    src_x  = XW'(s3_x_q);
    src_y  = YW'(s3_y_q);
    if (prm_i.mode[1]) begin
      src_y = (sy_sum >= fh_i) ? fh_i - YW'(1) : sy_sum;
    end else begin
      src_x = (sx_sum >= fw_i) ? fw_i - XW'(1) : sx_sum;
    end
    src_addr = AW'(src_y) * AW'(MAX_WIDTH) + AW'(src_x);
  end

  // Source read has the port; the handshake keeps new beats out then
  always_comb begin
    if (s3_v_q) begin
      ram_en   = 1'b1;
      ram_we   = 1'b0;
      ram_addr = src_addr;
    end else begin
      ram_en   = cmp_go || ld_go;
      ram_we   = ld_go;
      ram_addr = cur_addr;
    end
  end

  ldps_ram #(
    .DW    (24),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (pix_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmp_go;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  // S1: current pixel arrives; threshold test and luma * length
  logic [10:0] dist_raw;
  logic [9:0]  dist_d;

  always_ff @(posedge clk_i) begin
    s1_x_q    <= col_i;
    s1_y_q    <= line_i;
    s2_x_q    <= s1_x_q;
    s2_y_q    <= s1_y_q;
    s2_cur_q  <= ram_rdata;
    s2_pass_q <= (ram_rdata[7:0] < prm_i.ethr);
    s2_prod_q <= 20'(ram_rdata[7:0]) * 20'(prm_i.elen) + 20'd500;
    s3_x_q    <= s2_x_q;
    s3_y_q    <= s2_y_q;
    s3_cur_q  <= s2_cur_q;
    s3_pass_q <= s2_pass_q;
    s3_dist_q <= dist_d;
    s4_cur_q  <= s3_cur_q;
    s4_pass_q <= s3_pass_q;
  end

  // S2: distance, at least one step when the length is nonzero
  always_comb begin
    dist_raw = ldps_pkg::div1000(21'(s2_prod_q));
    dist_d   = dist_raw[9:0];
    if (dist_raw == 11'd0 && prm_i.elen != 12'd0) begin
      dist_d = 10'd1;
    end
  end

  // S4: source pixel arrives; optional average, then blend
  logic [7:0] cy, cb, cr, ty, tb, tr;
  logic [8:0] sum_y, sum_b, sum_r;

  always_comb begin
    cy    = s4_cur_q[7:0];
    cb    = s4_cur_q[15:8];
    cr    = s4_cur_q[23:16];
    sum_y = 9'(ram_rdata[7:0]) + 9'(cy) + 9'd1;
    sum_b = 9'(ram_rdata[15:8]) + 9'(cb);
    sum_r = 9'(ram_rdata[23:16]) + 9'(cr);
    if (prm_i.mode[0]) begin
      ty = sum_y[8:1];
      tb = sum_b[8:1];
      tr = sum_r[8:1];
    end else begin
      ty = ram_rdata[7:0];
      tb = ram_rdata[15:8];
      tr = ram_rdata[23:16];
    end
    if (s4_pass_q) begin
      res_o.luma    = cy;
      res_o.cb      = cb;
      res_o.cr      = cr;
      res_o.smeared = 1'b0;
    end else begin
      res_o.luma    = ldps_pkg::blend8(cy, ty, prm_i.mq);
      res_o.cb      = ldps_pkg::blend8(cb, tb, prm_i.cq);
      res_o.cr      = ldps_pkg::blend8(cr, tr, prm_i.cq);
      res_o.smeared = 1'b1;
    end
  end

  assign push_o        = s4_v_q;
  assign stat_o.src_rd = s3_v_q;
  assign stat_o.busy   = s1_v_q || s2_v_q || s3_v_q;
  assign stat_o.issue  = cmp_go;

endmodule

FILE: rtl/luma_driven_pixel_smear_core.sv
// ----------------------------------------------------------------------------
// luma_driven_pixel_smear_core
// Luma-driven pixel smear over a YCbCr frame store.
// ----------------------------------------------------------------------------
// A load beat writes one pixel into the single-port frame store. A compute
// beat uses that port twice, once for the current pixel and once for the
// source pixel; new beats are taken while earlier computes are in flight,
// but not while a source read holds the port. A result can leave the output
// queue in the cycle after it is pushed. A load is held off until every
// earlier compute has issued its source read. Results wait in an 8-deep
// queue, and computes are accepted while the results owed, in the pipeline
// or the queue, are fewer than its depth. After reset and after each write
// the input is held off while the derived settings settle. The frame store
// is not cleared; pixels must be loaded before they are computed.
module luma_driven_pixel_smear_core #(
  parameter int MAX_WIDTH  = ldps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ldps_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // col[9:0], line[19:10], luma_in[27:20], cb_in[35:28], cr_in[43:36]
  input  logic [ldps_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // opcode
  input  logic                            s_axis_tuser,
  // master side
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // luma_out[7:0], cb_out[15:8], cr_out[23:16]
  output logic [ldps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // smeared
  output logic                            m_axis_tuser,
  // register writes
  input  logic                            cfg_we_i,
  input  logic [ldps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ldps_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int XW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int YW = ($clog2(MAX_HEIGHT + 1) > 11) ? $clog2(MAX_HEIGHT + 1) : 11;
  localparam int PCW = $clog2(ldps_pkg::OFIFO_DEPTH + 1);
  localparam int RW  = $bits(ldps_pkg::ldps_res_t);

  ldps_pkg::ldps_prm_t  prm;
  ldps_pkg::ldps_stat_t stat;
  ldps_pkg::ldps_res_t  res, res_out;
  logic [XW-1:0]        fw;
  logic [YW-1:0]        fh;
  logic                 cfg_busy, push, accept, out_beat, credit_ok;
  logic [PCW-1:0]       pend_q, pend_d;

  ldps_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .XW         (XW),
    .YW         (YW)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .prm_o  (prm),
    .fw_o   (fw),
    .fh_o   (fh),
    .busy_o (cfg_busy)
  );

  // Results owed = beats in the pipeline plus beats in the queue
  assign credit_ok = (pend_q < PCW'(ldps_pkg::OFIFO_DEPTH));

  always_comb begin
    if (cfg_busy || stat.src_rd) begin
      s_axis_tready = 1'b0;
    end else if (s_axis_tuser == ldps_pkg::OP_COMPUTE) begin
      s_axis_tready = credit_ok;
    end else begin
      s_axis_tready = !stat.busy;
    end
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign pend_d   = pend_q + PCW'(stat.issue) - PCW'(out_beat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  ldps_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .XW         (XW),
    .YW         (YW)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (accept),
    .op_i   (s_axis_tuser),
    .col_i  (s_axis_tdata[9:0]),
    .line_i (s_axis_tdata[19:10]),
    .pix_i  (s_axis_tdata[43:20]),
    .prm_i  (prm),
    .fw_i   (fw),
    .fh_i   (fh),
    .stat_o (stat),
    .push_o (push),
    .res_o  (res)
  );

  ldps_fifo #(
    .DW    (RW),
    .DEPTH (ldps_pkg::OFIFO_DEPTH)
  ) u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (res_out)
  );

  assign m_axis_tdata = {res_out.cr, res_out.cb, res_out.luma};
  assign m_axis_tuser = res_out.smeared;

  // Owed results never exceed the queue depth
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PCW'(ldps_pkg::OFIFO_DEPTH))
    else $error("owed results exceed output queue depth");

  // A waiting result always has a credit outstanding
  a_out_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pend_q != PCW'(0)))
    else $error("result present with no outstanding credit");

  // Input is held off while new settings propagate
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input accepted while settings settle");

endmodule

FILE: tb/sv/luma_driven_pixel_smear_core_test.sv
// ----------------------------------------------------------------------------
// luma_driven_pixel_smear_core_test
// Self-checking bench for the pixel smear core. Pixels are loaded into the
// frame store and then computed. A predictor keeps its own copy of the store
// and the settings and works out each expected output pixel. Directed cases
// cover edges, modes and clamped settings. Random phases under varied
// settings and stall patterns follow, and a backpressure run fills the core.
// ----------------------------------------------------------------------------
module luma_driven_pixel_smear_core_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RX_HOLD_CYCLES = 150;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [ldps_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             s_axis_tuser = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [ldps_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tuser;
  logic                             cfg_we_i = 1'b0;
  logic [ldps_pkg::CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [ldps_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;

  // predictor copy of the registers
  logic [1:0]  set_mode = ldps_pkg::RST_MODE;
  logic [7:0]  set_thr = ldps_pkg::RST_THRESHOLD;
  logic [11:0] set_len = ldps_pkg::RST_LENGTH;
  logic [9:0]  set_mix = ldps_pkg::RST_MIX;
  logic [9:0]  set_chroma = ldps_pkg::RST_CHROMA;
  logic [9:0]  set_drive = ldps_pkg::RST_DRIVE;
  logic [10:0] set_fw = ldps_pkg::RST_FW;
  logic [10:0] set_fh = ldps_pkg::RST_FH;

  // settings after clamping and drive
  int unsigned eff_fw, eff_fh, eff_thr, eff_len, eff_mq, eff_cq;

  logic [23:0]         frame_mem [int unsigned];
  ldps_pkg::ldps_res_t expected_px [$];

  int tx_idle_pct = 13;
  int rx_idle_pct = 46;
  int rx_hold_req = 0;
  int rx_hold_ack = 0;
  int rx_hold_left = 0;
  int cycle_cnt = 0;
  int err_cnt = 0;
  int n_loads = 0, n_computes = 0, n_smeared = 0, n_passed = 0, n_outside = 0;
  int n_settings = 0;

  luma_driven_pixel_smear_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned clip(input int unsigned v, lo, hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned pix_addr(input int unsigned x, y);
    return y * ldps_pkg::MAX_WIDTH_DEF + x;
  endfunction

  function automatic bit in_frame(input int unsigned x, y);
    return x < eff_fw && y < eff_fh;
  endfunction

  function automatic void update_derived();
    int unsigned mix, chr, drv, dthr, emix, echr;
    eff_fw = clip(set_fw, 1, ldps_pkg::MAX_WIDTH_DEF);
    eff_fh = clip(set_fh, 1, ldps_pkg::MAX_HEIGHT_DEF);
    mix = clip(set_mix, 0, 1000);
    chr = clip(set_chroma, 0, 1000);
    drv = clip(set_drive, 0, 1000);
    dthr = (drv * 96 + 500) / 1000;
    eff_thr = set_thr > dthr ? set_thr - dthr : 0;
    eff_len = clip(clip(set_len, 0, 3000) + (drv * 2000 + 500) / 1000, 0, 3000);
    emix = mix + ((1000 - mix) * drv + 500) / 1000;
    echr = chr + ((1000 - chr) * drv + 500) / 1000;
    eff_mq = (emix * 256 + 500) / 1000;
    eff_cq = (eff_mq * ((echr * 256 + 500) / 1000) + 128) >> 8;
  endfunction

  // q is an 8-bit fraction, 0..256
  function automatic logic [7:0] q8_mix(input int unsigned a, b, q);
    int unsigned s;
    s = (a * (256 - q) + b * q + 128) >> 8;
    return 8'(s);
  endfunction

  // Returns 1 when the pixel gets smeared; src_at is the store index it reads.
  function automatic bit locate_source(input int unsigned x, y, output int unsigned src_at);
    int unsigned cy, step_len, sx, sy;
    cy = frame_mem[pix_addr(x, y)][7:0];
    src_at = pix_addr(x, y);
    if (cy < eff_thr) return 0;
    step_len = (cy * eff_len + 500) / 1000;
    if (step_len < 1 && eff_len > 0) step_len = 1;
    sx = x;
    sy = y;
    // mode bit 1 selects vertical, bit 0 averaging
    if (set_mode[1]) sy = (y + step_len >= eff_fh) ? eff_fh - 1 : y + step_len;
    else sx = (x + step_len >= eff_fw) ? eff_fw - 1 : x + step_len;
    src_at = pix_addr(sx, sy);
    return 1;
  endfunction

  function automatic bit predict_smear(input int unsigned x, y,
                                       output ldps_pkg::ldps_res_t px);
    logic [23:0] cur, src;
    int unsigned src_at, ty, tb, tr;
    px = '0;
    if (!in_frame(x, y)) return 0;
    cur = frame_mem[pix_addr(x, y)];
    px.luma = cur[7:0];
    px.cb = cur[15:8];
    px.cr = cur[23:16];
    if (!locate_source(x, y, src_at)) return 1;
    src = frame_mem[src_at];
    ty = src[7:0];
    tb = src[15:8];
    tr = src[23:16];
    if (set_mode[0]) begin
      ty = (ty + cur[7:0] + 1) >> 1;
      tb = (tb + cur[15:8]) >> 1;
      tr = (tr + cur[23:16]) >> 1;
    end
    px.luma = q8_mix(cur[7:0], ty, eff_mq);
    px.cb = q8_mix(cur[15:8], tb, eff_cq);
    px.cr = q8_mix(cur[23:16], tr, eff_cq);
    px.smeared = 1'b1;
    return 1;
  endfunction

  // ------------------------------------------------------------------ driving

  task automatic send_beat(input logic op, input logic [9:0] x, y,
                           input logic [7:0] yv, cbv, crv);
    int gap;
    ldps_pkg::ldps_res_t px;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'b0, crv, cbv, yv, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == ldps_pkg::OP_LOAD) begin
      frame_mem[pix_addr(x, y)] = {crv, cbv, yv};
      n_loads++;
    end else begin
      n_computes++;
      if (predict_smear(x, y, px)) begin
        expected_px.push_back(px);
        if (px.smeared) n_smeared++;
        else n_passed++;
      end else begin
        n_outside++;
      end
    end
  endtask

  task automatic load_random(input int unsigned x, y);
    send_beat(ldps_pkg::OP_LOAD, 10'(x), 10'(y), 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  // Compute one pixel; the pixel and its source are loaded first if still unwritten.
  task automatic smear_pixel(input int unsigned x, y);
    int unsigned src_at;
    if (!frame_mem.exists(pix_addr(x, y))) load_random(x, y);
    if (in_frame(x, y) && locate_source(x, y, src_at) && !frame_mem.exists(src_at))
      load_random(src_at % ldps_pkg::MAX_WIDTH_DEF, src_at / ldps_pkg::MAX_WIDTH_DEF);
    send_beat(ldps_pkg::OP_COMPUTE, 10'(x), 10'(y), 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  task automatic wait_pixels_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      ldps_pkg::REG_MODE:         set_mode = val[1:0];
      ldps_pkg::REG_THRESHOLD:    set_thr = val[7:0];
      ldps_pkg::REG_SMEAR_LENGTH: set_len = val;
      ldps_pkg::REG_MIX:          set_mix = val[9:0];
      ldps_pkg::REG_CHROMA:       set_chroma = val[9:0];
      ldps_pkg::REG_DRIVE:        set_drive = val[9:0];
      ldps_pkg::REG_FRAME_WIDTH:  set_fw = val[10:0];
      default:                    set_fh = val[10:0];
    endcase
    update_derived();
  endtask

  // ----------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    ldps_pkg::ldps_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_px.size() == 0) begin
        $error("output beat with nothing pending: tdata %h smeared %b",
               m_axis_tdata, m_axis_tuser);
        err_cnt++;
      end else begin
        want = expected_px.pop_front();
        if (m_axis_tdata[7:0] !== want.luma) begin
          $error("luma_out: expected %0d, got %0d", want.luma, m_axis_tdata[7:0]);
          err_cnt++;
        end
        if (m_axis_tdata[15:8] !== want.cb) begin
          $error("cb_out: expected %0d, got %0d", want.cb, m_axis_tdata[15:8]);
          err_cnt++;
        end
        if (m_axis_tdata[23:16] !== want.cr) begin
          $error("cr_out: expected %0d, got %0d", want.cr, m_axis_tdata[23:16]);
          err_cnt++;
        end
        if (m_axis_tuser !== want.smeared) begin
          $error("smeared: expected %0d, got %0d", want.smeared, m_axis_tuser);
          err_cnt++;
        end
      end
    end
    if (rx_hold_ack != rx_hold_req) begin
      rx_hold_ack = rx_hold_req;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // -------------------------------------------------------------------- tests

  task automatic test_directed_defaults();
    send_beat(ldps_pkg::OP_LOAD, 10'd0, 10'd0, 8'd0, 8'h80, 8'h80);
    smear_pixel(0, 0);           // luma below threshold
    send_beat(ldps_pkg::OP_LOAD, 10'd1023, 10'd1023, 8'hFF, 8'hFF, 8'hFF);
    smear_pixel(1023, 1023);     // source clamps onto itself
    send_beat(ldps_pkg::OP_LOAD, 10'd0, 10'd1, 8'd200, 8'd0, 8'hFF);
    smear_pixel(0, 1);
  endtask

  task automatic test_directed_modes();
    wait_pixels_drained();
    write_reg(ldps_pkg::REG_MODE, 12'd3);
    write_reg(ldps_pkg::REG_FRAME_WIDTH, 12'd16);
    write_reg(ldps_pkg::REG_FRAME_HEIGHT, 12'd16);
    write_reg(ldps_pkg::REG_SMEAR_LENGTH, 12'd3000);
    send_beat(ldps_pkg::OP_LOAD, 10'd3, 10'd3, 8'hFF, 8'h00, 8'hFF);
    smear_pixel(3, 3);           // vertical average, clamped to last row
    wait_pixels_drained();
    write_reg(ldps_pkg::REG_MODE, 12'd1);
    smear_pixel(3, 3);           // horizontal average, clamped to last column
    smear_pixel(20, 3);          // outside the frame: no output
    smear_pixel(3, 700);
    wait_pixels_drained();
    write_reg(ldps_pkg::REG_SMEAR_LENGTH, 12'd0);
    smear_pixel(3, 3);           // zero length: marked smeared, values unchanged
  endtask

  task automatic test_directed_clamps();
    wait_pixels_drained();
    write_reg(ldps_pkg::REG_MODE, 12'd2);
    write_reg(ldps_pkg::REG_THRESHOLD, 12'd255);
    write_reg(ldps_pkg::REG_SMEAR_LENGTH, 12'd4095);
    write_reg(ldps_pkg::REG_MIX, 12'd1023);
    write_reg(ldps_pkg::REG_CHROMA, 12'd1023);
    write_reg(ldps_pkg::REG_DRIVE, 12'd1023);
    write_reg(ldps_pkg::REG_FRAME_WIDTH, 12'd0);
    write_reg(ldps_pkg::REG_FRAME_HEIGHT, 12'd2047);
    smear_pixel(0, 0);
    send_beat(ldps_pkg::OP_LOAD, 10'd0, 10'd5, 8'd200, 8'd17, 8'd230);
    smear_pixel(0, 5);
    wait_pixels_drained();
    write_reg(ldps_pkg::REG_DRIVE, 12'd0);
    write_reg(ldps_pkg::REG_MIX, 12'd0);
    write_reg(ldps_pkg::REG_CHROMA, 12'd0);
    write_reg(ldps_pkg::REG_SMEAR_LENGTH, 12'd3000);
    write_reg(ldps_pkg::REG_FRAME_WIDTH, 12'd1024);
    smear_pixel(0, 5);           // 200 is below a threshold of 255
    send_beat(ldps_pkg::OP_LOAD, 10'd2, 10'd2, 8'hFF, 8'd40, 8'd90);
    smear_pixel(2, 2);           // zero mix keeps the pixel
    wait_pixels_drained();
    write_reg(ldps_pkg::REG_MIX, 12'd500);
    write_reg(ldps_pkg::REG_CHROMA, 12'd1);
    smear_pixel(2, 2);
  endtask

  function automatic logic [11:0] pick_size();
    case ($urandom_range(9))
      7:       return 12'd1024;
      8:       return 12'($urandom_range(2047));
      9:       return 12'($urandom_range(1));
      default: return 12'($urandom_range(24, 1));
    endcase
  endfunction

  function automatic logic [11:0] pick_permille();
    case ($urandom_range(5))
      0:       return 12'd0;
      1:       return 12'd1000;
      2:       return 12'd1023;
      default: return 12'($urandom_range(1000));
    endcase
  endfunction

  task automatic pick_random_settings();
    logic [11:0] len;
    wait_pixels_drained();
    case ($urandom_range(9))
      0:       len = 12'd0;
      1:       len = 12'd3000;
      2:       len = 12'd4095;
      3:       len = 12'd1;
      default: len = 12'($urandom_range(3000));
    endcase
    write_reg(ldps_pkg::REG_MODE, 12'($urandom_range(3)));
    write_reg(ldps_pkg::REG_THRESHOLD,
              $urandom_range(2) == 0 ? 12'd0 : 12'($urandom_range(255)));
    write_reg(ldps_pkg::REG_SMEAR_LENGTH, len);
    write_reg(ldps_pkg::REG_MIX, pick_permille());
    write_reg(ldps_pkg::REG_CHROMA, pick_permille());
    write_reg(ldps_pkg::REG_DRIVE, $urandom_range(1) ? 12'd0 : pick_permille());
    write_reg(ldps_pkg::REG_FRAME_WIDTH, pick_size());
    write_reg(ldps_pkg::REG_FRAME_HEIGHT, pick_size());
    n_settings++;
  endtask

  task automatic run_random_items(input int count);
    int unsigned r, x, y;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 30) begin
        load_random($urandom_range(eff_fw - 1), $urandom_range(eff_fh - 1));
      end else if (r < 40) begin
        load_random($urandom_range(1023), $urandom_range(1023));
      end else if (r < 47 && (eff_fw < 1024 || eff_fh < 1024)) begin
        if (eff_fw < 1024 && (eff_fh == 1024 || $urandom_range(1))) begin
          x = $urandom_range(1023, eff_fw);
          y = $urandom_range(1023);
        end else begin
          x = $urandom_range(1023);
          y = $urandom_range(1023, eff_fh);
        end
        smear_pixel(x, y);
      end else begin
        smear_pixel($urandom_range(eff_fw - 1), $urandom_range(eff_fh - 1));
      end
    end
  endtask

  task automatic test_random_settings();
    for (int prof = 0; prof < 3; prof++) begin
      tx_idle_pct = prof == 0 ? 13 : (prof == 1 ? 46 : 0);
      rx_idle_pct = prof == 0 ? 46 : (prof == 1 ? 13 : 0);
      repeat (4) begin
        pick_random_settings();
        run_random_items(95);
      end
    end
  endtask

  // Receiver holds off while the sender streams, then the sender waits for every
  // pending pixel before it goes on.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_pixels_drained();
    write_reg(ldps_pkg::REG_FRAME_WIDTH, 12'd8);
    write_reg(ldps_pkg::REG_FRAME_HEIGHT, 12'd8);
    rx_hold_req++;
    run_random_items(60);
    wait_pixels_drained();
    run_random_items(40);
  endtask

  initial begin
    update_derived();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_defaults();
    test_directed_modes();
    test_directed_clamps();
    test_random_settings();
    test_backpressure();
    wait_pixels_drained();
    if (expected_px.size() != 0) begin
      $error("%0d output pixels never arrived", expected_px.size());
      err_cnt++;
    end
    $display("Covered %0d loads and %0d computes over %0d random settings.",
             n_loads, n_computes, n_settings);
    $display("Computes: %0d smeared, %0d below threshold, %0d outside the frame.",
             n_smeared, n_passed, n_outside);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ldps_pkg.sv
rtl/ldps_ram.sv
rtl/ldps_cfg.sv
rtl/ldps_fifo.sv
rtl/ldps_dpath.sv
rtl/luma_driven_pixel_smear_core.sv
tb/sv/luma_driven_pixel_smear_core_test.sv
